// ===== sv/tsc_pkg.sv =====
`default_nettype none

package tsc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W = SAMPLE_W + 2;
    localparam int OUT_W = 9;
    localparam int POS_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam int SCREEN_WIDTH_DEF = 480;
    localparam int SCREEN_HEIGHT_DEF = 320;
    localparam int DIV_STEPS_PER_STAGE = 3;

    localparam logic [SAMPLE_W-1:0] PRESS_Z1_MIN = 12'd100;
    localparam logic [SAMPLE_W-1:0] PRESS_Z2_MAX = 12'd3900;

    localparam logic [SAMPLE_W-1:0] XCHAN_LOW_RST = 12'd260;
    localparam logic [SAMPLE_W-1:0] XCHAN_HIGH_RST = 12'd1798;
    localparam logic [SAMPLE_W-1:0] YCHAN_LOW_RST = 12'd211;
    localparam logic [SAMPLE_W-1:0] YCHAN_HIGH_RST = 12'd1853;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XCHAN_LOW,
        REG_XCHAN_HIGH,
        REG_YCHAN_LOW,
        REG_YCHAN_HIGH
    } cfg_reg_t;

    typedef struct packed {
        logic neg;
        logic degen;
        logic sat;
    } axis_flags_t;

    typedef struct packed {
        logic                pressed;
        logic [SAMPLE_W-1:0] avg_x;
        logic [SAMPLE_W-1:0] avg_y;
    } carry_t;

endpackage

`default_nettype wire

// ===== sv/tsc_axis.sv =====
`default_nettype none

module tsc_axis #(
    parameter int SIZE = tsc_pkg::SCREEN_WIDTH_DEF,
    parameter int STAGES = 3
) (
    input  wire logic                          clk,
    input  wire logic [STAGES+1:0]             en,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  avg,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  lo,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  hi,
    output tsc_pkg::axis_flags_t               flags,
    output logic [$clog2(SIZE)-1:0]            quot
);

    import tsc_pkg::*;

    localparam int QW = $clog2(SIZE);
    localparam int NW = SAMPLE_W + QW;
    localparam int SPS = (QW + STAGES - 1) / STAGES;

    logic [SAMPLE_W-1:0] mag_reg;
    logic [SAMPLE_W-1:0] den1_reg;
    logic                neg1_reg;
    logic                degen1_reg;

    logic [NW-1:0]       prod_reg;
    logic [SAMPLE_W-1:0] den2_reg;
    axis_flags_t         flg2_reg;

    logic [SAMPLE_W-1:0] rem_reg [STAGES];
    logic [QW-1:0]       nlo_reg [STAGES];
    logic [QW-1:0]       quo_reg [STAGES];
    logic [SAMPLE_W-1:0] den_reg [STAGES];
    axis_flags_t         flg_reg [STAGES];

    logic [SAMPLE_W-1:0] rem_next [STAGES];
    logic [QW-1:0]       nlo_next [STAGES];
    logic [QW-1:0]       quo_next [STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg1_reg   <= (avg < lo);
            mag_reg    <= (avg >= lo) ? (avg - lo) : (lo - avg);
            den1_reg   <= hi - lo;
            degen1_reg <= (hi <= lo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg       <= NW'(mag_reg) * NW'(SIZE);
            den2_reg       <= den1_reg;
            flg2_reg.neg   <= neg1_reg;
            flg2_reg.degen <= degen1_reg;
            flg2_reg.sat   <= !neg1_reg && (mag_reg >= den1_reg);
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_div
        logic [SAMPLE_W-1:0] rem_in;
        logic [QW-1:0]       nlo_in;
        logic [QW-1:0]       quo_in;
        logic [SAMPLE_W-1:0] den_in;
        axis_flags_t         flg_in;

        if (s == 0)
        begin : g_first
            assign rem_in = prod_reg[NW-1:QW];
            assign nlo_in = prod_reg[QW-1:0];
            assign quo_in = '0;
            assign den_in = den2_reg;
            assign flg_in = flg2_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign nlo_in = nlo_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
            assign flg_in = flg_reg[s-1];
        end

        always_comb
        begin
            logic [SAMPLE_W:0]   trial;
            logic [SAMPLE_W-1:0] r;
            logic [QW-1:0]       n;
            logic [QW-1:0]       q;
            logic                qbit;
            trial = '0;
            qbit = 1'b0;
            r = rem_in;
            n = nlo_in;
            q = quo_in;
            for (int t = 0; t < SPS; t++)
            begin
                if (s * SPS + t < QW)
                begin
                    trial = {r, n[QW-1]};
                    n = n << 1;
                    qbit = (trial >= {1'b0, den_in});
                    if (qbit)
                    begin
                        r = SAMPLE_W'(trial - {1'b0, den_in});
                    end
                    else
                    begin
                        r = trial[SAMPLE_W-1:0];
                    end
                    q = (q << 1) | QW'(qbit);
                end
            end
            rem_next[s] = r;
            nlo_next[s] = n;
            quo_next[s] = q;
        end

        always_ff @(posedge clk)
        begin
            if (en[2+s])
            begin
                rem_reg[s] <= rem_next[s];
                nlo_reg[s] <= nlo_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_in;
                flg_reg[s] <= flg_in;
            end
        end
    end

    assign quot  = quo_reg[STAGES-1];
    assign flags = flg_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/touch_sample_calibrator_core.sv =====
`default_nettype none

// Calibrates one resistive touch report per item: the pressure test, the
// truncated means of the four X and four Y samples, and the scaled and clamped
// screen column and row. The block is a fully pipelined datapath that takes one
// item every cycle while back-pressure from the output does not stall it. The
// restoring divider that scales each axis resolves up to three quotient bits in
// each of its stages. Stages whose item has moved on refill even while the
// output is held, so bubbles close up under back-pressure. The user must write
// the calibration registers through the configuration port only while no item
// is in flight; the block itself does not enforce this.

module touch_sample_calibrator_core #(
    parameter int SCREEN_WIDTH = tsc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tsc_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  z1_pressure,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  z2_pressure,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  xchan_s0,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  xchan_s1,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  xchan_s2,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  xchan_s3,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  ychan_s0,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  ychan_s1,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  ychan_s2,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  ychan_s3,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               pressed,
    output logic [tsc_pkg::OUT_W-1:0]          screen_col,
    output logic [tsc_pkg::OUT_W-1:0]          screen_row,
    output logic [tsc_pkg::SAMPLE_W-1:0]       avg_xchan,
    output logic [tsc_pkg::SAMPLE_W-1:0]       avg_ychan,
    input  wire logic                          cfg_we,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsc_pkg::SAMPLE_W-1:0]  cfg_data
);

    import tsc_pkg::*;

    localparam int QW_COL = $clog2(SCREEN_WIDTH);
    localparam int QW_ROW = $clog2(SCREEN_HEIGHT);
    localparam int QW_MAX = (QW_COL > QW_ROW) ? QW_COL : QW_ROW;
    localparam int DIV_STAGES = (QW_MAX + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int NST = DIV_STAGES + 4;
    localparam int OUT_STAGE = NST - 1;

    localparam logic [POS_W-1:0] COL_MAX = POS_W'(SCREEN_WIDTH - 1);
    localparam logic [POS_W-1:0] ROW_MAX = POS_W'(SCREEN_HEIGHT - 1);

    logic [SAMPLE_W-1:0] xchan_low_reg;
    logic [SAMPLE_W-1:0] xchan_high_reg;
    logic [SAMPLE_W-1:0] ychan_low_reg;
    logic [SAMPLE_W-1:0] ychan_high_reg;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    carry_t carry_reg [OUT_STAGE];
    carry_t carry_next;

    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;

    axis_flags_t         col_flags;
    axis_flags_t         row_flags;
    logic [QW_COL-1:0]   col_quot;
    logic [QW_ROW-1:0]   row_quot;

    logic [POS_W-1:0] col_val;
    logic [POS_W-1:0] row_val;

    logic                pressed_reg;
    logic [OUT_W-1:0]    col_reg;
    logic [OUT_W-1:0]    row_reg;
    logic [SAMPLE_W-1:0] avg_x_reg;
    logic [SAMPLE_W-1:0] avg_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xchan_low_reg  <= XCHAN_LOW_RST;
            xchan_high_reg <= XCHAN_HIGH_RST;
            ychan_low_reg  <= YCHAN_LOW_RST;
            ychan_high_reg <= YCHAN_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_XCHAN_LOW:  xchan_low_reg  <= cfg_data;
                REG_XCHAN_HIGH: xchan_high_reg <= cfg_data;
                REG_YCHAN_LOW:  ychan_low_reg  <= cfg_data;
                REG_YCHAN_HIGH: ychan_high_reg <= cfg_data;
                default:        xchan_low_reg  <= xchan_low_reg;
            endcase
        end
    end

    // A stage may load when it is empty or when its item moves on.
    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        sum_x = SUM_W'(xchan_s0) + SUM_W'(xchan_s1) + SUM_W'(xchan_s2) + SUM_W'(xchan_s3);
        sum_y = SUM_W'(ychan_s0) + SUM_W'(ychan_s1) + SUM_W'(ychan_s2) + SUM_W'(ychan_s3);
        carry_next.pressed = (z1_pressure >= PRESS_Z1_MIN) && (z2_pressure <= PRESS_Z2_MAX);
        carry_next.avg_x   = sum_x[SUM_W-1:2];
        carry_next.avg_y   = sum_y[SUM_W-1:2];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            carry_reg[0] <= carry_next;
        end
        for (int k = 1; k < OUT_STAGE; k++)
        begin
            if (en[k])
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    tsc_axis #(
        .SIZE   (SCREEN_WIDTH),
        .STAGES (DIV_STAGES)
    ) u_col (
        .clk   (clk),
        .en    (en[DIV_STAGES+2:1]),
        .avg   (carry_reg[0].avg_y),
        .lo    (ychan_low_reg),
        .hi    (ychan_high_reg),
        .flags (col_flags),
        .quot  (col_quot)
    );

    tsc_axis #(
        .SIZE   (SCREEN_HEIGHT),
        .STAGES (DIV_STAGES)
    ) u_row (
        .clk   (clk),
        .en    (en[DIV_STAGES+2:1]),
        .avg   (carry_reg[0].avg_x),
        .lo    (xchan_low_reg),
        .hi    (xchan_high_reg),
        .flags (row_flags),
        .quot  (row_quot)
    );

    // A sample below the low calibration value gives a negative offset, so the column
    // clamps to its first pixel and the flipped row to its last.
    always_comb
    begin
        if (!carry_reg[OUT_STAGE-1].pressed || col_flags.degen || col_flags.neg)
        begin
            col_val = '0;
        end
        else if (col_flags.sat)
        begin
            col_val = COL_MAX;
        end
        else
        begin
            col_val = POS_W'(col_quot);
        end

        if (!carry_reg[OUT_STAGE-1].pressed || row_flags.degen)
        begin
            row_val = '0;
        end
        else if (row_flags.neg)
        begin
            row_val = ROW_MAX;
        end
        else if (row_flags.sat)
        begin
            row_val = '0;
        end
        else
        begin
            row_val = ROW_MAX - POS_W'(row_quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_STAGE])
        begin
            pressed_reg <= carry_reg[OUT_STAGE-1].pressed;
            col_reg     <= col_val[OUT_W-1:0];
            row_reg     <= row_val[OUT_W-1:0];
            avg_x_reg   <= carry_reg[OUT_STAGE-1].pressed ? carry_reg[OUT_STAGE-1].avg_x : '0;
            avg_y_reg   <= carry_reg[OUT_STAGE-1].pressed ? carry_reg[OUT_STAGE-1].avg_y : '0;
        end
    end

    assign out_valid  = valid_reg[OUT_STAGE];
    assign pressed    = pressed_reg;
    assign screen_col = col_reg;
    assign screen_row = row_reg;
    assign avg_xchan  = avg_x_reg;
    assign avg_ychan  = avg_y_reg;

endmodule

`default_nettype wire
